// ===== rtl/sise_pkg.sv =====
// types, codes and class limits shared by the sorted integer set engine
package sise_pkg;

	typedef enum logic [1:0] {
		REQ_ADD    = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_READ   = 2'd3
	} req_type_t;

	localparam logic [1:0] WC_16 = 2'd0;
	localparam logic [1:0] WC_32 = 2'd1;
	localparam logic [1:0] WC_64 = 2'd2;

	localparam logic signed [63:0] CLASS16_LO = -64'sd32768;
	localparam logic signed [63:0] CLASS16_HI = 64'sd32767;
	localparam logic signed [63:0] CLASS32_LO = -64'sd2147483648;
	localparam logic signed [63:0] CLASS32_HI = 64'sd2147483647;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [63:0] value;
		logic [7:0]         index;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [8:0]         position;
		logic signed [63:0] read_value;
		logic [8:0]         count;
		logic [1:0]         width_class;
		logic               full_res;
	} res_t;

	// narrowest width class that holds v
	function automatic logic [1:0] class_of(input logic signed [63:0] v);
		logic [1:0] c;
		if (v < CLASS32_LO || v > CLASS32_HI) begin
			c = WC_64;
		end else if (v < CLASS16_LO || v > CLASS16_HI) begin
			c = WC_32;
		end else begin
			c = WC_16;
		end
		return c;
	endfunction

endpackage

// ===== rtl/sorted_integer_set_engine.sv =====
// sorted integer set engine: sequencer, entry memory and result register
//
// channel   dir  handshake            word
// req       in   req_valid/req_stall  req_type, value, index
// res       out  res_valid/res_stall  ok, position, read_value, count, width_class, full_res
//
// search: at most ceil(log2(count+1)) probes, each a read in SRCH and a compare in CMP, then a closing SRCH step
// an add moves count-pos entries, a remove count-pos-1, one per cycle
// an add then writes the new value in PUT; every request ends in FIN
// read by index goes through RDW to FIN, or straight to FIN when out of range
// reset empties the table at once; no clearing pass, the entry memory is not reset
// req_stall is high while an item is at work; res is a register, a stalled result holds
module sorted_integer_set_engine #(
	parameter int CAPACITY = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sise_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output sise_pkg::res_t res
);
	import sise_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMPW = (CW > 8) ? CW : 8;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SRCH = 7'b0000010,
		ST_CMP  = 7'b0000100,
		ST_MOVE = 7'b0001000,
		ST_PUT  = 7'b0010000,
		ST_RDW  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [1:0]         type_q;
	logic signed [63:0] v_q;
	logic [CW-1:0]      lo_q;
	logic [CW-1:0]      hi_q;
	logic [CW-1:0]      mid_q;
	logic               found_q;
	logic               ok_q;
	logic               full_q;
	logic [8:0]         pos_q;
	logic [63:0]        rd_q;
	logic [CW-1:0]      count_q;
	logic [1:0]         level_q;
	logic [CW-1:0]      mv_left_q;
	logic [IW-1:0]      rd_ptr_q;
	logic               up_q;
	logic               mv_s1;
	logic [IW-1:0]      dst_s1;
	logic               res_valid_q;
	res_t               res_q;

	logic [63:0]        mem [CAPACITY];
	logic [63:0]        rdata_q;
	logic               mem_re;
	logic [IW-1:0]      mem_raddr;
	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	logic [63:0]        mem_wdata;

	logic [CW-1:0]      mid;
	logic               idx_in_range;
	logic [1:0]         need;

	assign mid          = lo_q + ((hi_q - lo_q) >> 1);
	assign idx_in_range = CMPW'(req.index) < CMPW'(count_q);
	assign need         = class_of(v_q);

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = rd_ptr_q;
		mem_we    = 1'b0;
		mem_waddr = dst_s1;
		mem_wdata = rdata_q;
		case (state_q)
			ST_IDLE: begin
				mem_re    = req_valid && (req.req_type == REQ_READ) && idx_in_range;
				mem_raddr = IW'(req.index);
			end
			ST_SRCH: begin
				mem_re    = (lo_q < hi_q);
				mem_raddr = IW'(mid);
			end
			ST_MOVE: begin
				mem_re    = (mv_left_q != '0);
				mem_we    = mv_s1;
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				mem_waddr = IW'(lo_q);
				mem_wdata = v_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			type_q      <= REQ_ADD;
			v_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			mid_q       <= '0;
			found_q     <= 1'b0;
			ok_q        <= 1'b0;
			full_q      <= 1'b0;
			pos_q       <= '0;
			rd_q        <= '0;
			count_q     <= '0;
			level_q     <= WC_16;
			mv_left_q   <= '0;
			rd_ptr_q    <= '0;
			up_q        <= 1'b0;
			mv_s1       <= 1'b0;
			dst_s1      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall && state_q != ST_FIN) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						type_q  <= req.req_type;
						v_q     <= req.value;
						lo_q    <= '0;
						hi_q    <= count_q;
						found_q <= 1'b0;
						ok_q    <= (req.req_type == REQ_READ) && idx_in_range;
						full_q  <= 1'b0;
						rd_q    <= '0;
						if (req.req_type == REQ_READ) begin
							pos_q <= 9'(req.index);
							if (idx_in_range) begin
								state_q <= ST_RDW;
							end else begin
								state_q <= ST_FIN;
							end
						end else begin
							state_q <= ST_SRCH;
						end
					end
				end
				ST_SRCH: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid;
						state_q <= ST_CMP;
					end else begin
						pos_q <= 9'(lo_q);
						case (type_q)
							REQ_FIND: begin
								ok_q    <= found_q;
								state_q <= ST_FIN;
							end
							REQ_REMOVE: begin
								if (found_q) begin
									ok_q      <= 1'b1;
									mv_left_q <= count_q - lo_q - CW'(1);
									rd_ptr_q  <= IW'(lo_q + CW'(1));
									up_q      <= 1'b0;
									state_q   <= ST_MOVE;
								end else begin
									state_q <= ST_FIN;
								end
							end
							REQ_ADD: begin
								if (found_q) begin
									state_q <= ST_FIN;
								end else if (count_q == CW'(CAPACITY)) begin
									full_q  <= 1'b1;
									state_q <= ST_FIN;
								end else begin
									ok_q      <= 1'b1;
									mv_left_q <= count_q - lo_q;
									rd_ptr_q  <= IW'(count_q - CW'(1));
									up_q      <= 1'b1;
									state_q   <= ST_MOVE;
								end
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_CMP: begin
					// lower bound; distinct entries make a hit the final position
					if ($signed(rdata_q) < v_q) begin
						lo_q <= mid_q + CW'(1);
					end else begin
						hi_q <= mid_q;
					end
					if ($signed(rdata_q) == v_q) begin
						found_q <= 1'b1;
					end
					state_q <= ST_SRCH;
				end
				ST_MOVE: begin
					// read one entry per cycle, write it one slot over the next cycle
					if (mv_left_q != '0) begin
						mv_left_q <= mv_left_q - CW'(1);
						mv_s1     <= 1'b1;
						if (up_q) begin
							rd_ptr_q <= rd_ptr_q - IW'(1);
							dst_s1   <= rd_ptr_q + IW'(1);
						end else begin
							rd_ptr_q <= rd_ptr_q + IW'(1);
							dst_s1   <= rd_ptr_q - IW'(1);
						end
					end else begin
						mv_s1 <= 1'b0;
					end
					if (mv_left_q == '0 && !mv_s1) begin
						if (up_q) begin
							state_q <= ST_PUT;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= ST_FIN;
						end
					end
				end
				ST_PUT: begin
					count_q <= count_q + CW'(1);
					if (need > level_q) begin
						level_q <= need;
					end
					state_q <= ST_FIN;
				end
				ST_RDW: begin
					rd_q    <= rdata_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_q.ok          <= ok_q;
						res_q.position    <= pos_q;
						res_q.read_value  <= rd_q;
						res_q.count       <= 9'(count_q);
						res_q.width_class <= level_q;
						res_q.full_res    <= full_q;
						res_valid_q       <= 1'b1;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == $past(count_q) + CW'(1)
		|| count_q == $past(count_q) - CW'(1))
		else $error("entry count moved by more than one");

	a_level_grows: assert property (@(posedge clk) disable iff (!arst_n)
		level_q >= $past(level_q))
		else $error("width class narrowed");

	a_move_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 |-> state_q == ST_MOVE)
		else $error("pending tail write outside move");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && full_q) |-> !ok_q && count_q == CW'(CAPACITY))
		else $error("refused add with room left or flagged ok");

endmodule

// ===== tb/sorted_integer_set_engine_tb.sv =====
// self-checking testbench for the sorted integer set engine
`timescale 1ns / 100ps

module sorted_integer_set_engine_tb;
	import sise_pkg::*;

	localparam int SET_CAP = 256;
	localparam logic signed [63:0] INT64_MIN = {1'b1, {63{1'b0}}};
	localparam logic signed [63:0] INT64_MAX = {1'b0, {63{1'b1}}};

	typedef struct {
		req_t w;
		bit   typed;
		res_t want;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic res_valid;
	logic res_stall;
	res_t res;

	// shadow copy of the table
	logic signed [63:0] shadow_set [SET_CAP];
	int                 shadow_count = 0;
	logic [1:0]         shadow_class = WC_16;

	res_t        answers_due [$];
	script_row_t script [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int fails = 0;
	int checked = 0;
	int refused = 0;
	int refused_mark = 0;
	int peak = 0;
	int op_tally [4];
	bit filling = 1'b1;

	sorted_integer_set_engine #(
		.CAPACITY(SET_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [1:0] width_need(input logic signed [63:0] v);
		logic [1:0] c;
		if (v < CLASS32_LO || v > CLASS32_HI) begin
			c = WC_64;
		end else if (v < CLASS16_LO || v > CLASS16_HI) begin
			c = WC_32;
		end else begin
			c = WC_16;
		end
		return c;
	endfunction

	// applies one request to the shadow table and returns the answer it owes
	function automatic res_t set_answer(input req_t w);
		res_t               a;
		logic signed [63:0] v;
		logic [1:0]         need;
		int                 lo, hi, mid, at, i;
		bit                 hit, fresh;
		a = '0;
		v = w.value;
		lo = 0;
		hi = shadow_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (shadow_set[mid] < v) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		hit = (lo < shadow_count) && (shadow_set[lo] == v);
		need = width_need(v);
		op_tally[w.req_type]++;
		case (w.req_type)
			REQ_ADD: begin
				// a wider value lands before every stored one if negative, else after every one
				if (need > shadow_class) begin
					at = (v < 0) ? 0 : shadow_count;
					fresh = 1'b1;
				end else begin
					at = lo;
					fresh = !hit;
				end
				a.position = 9'(at);
				if (fresh && shadow_count >= SET_CAP) begin
					a.full_res = 1'b1;
					refused++;
				end else if (fresh) begin
					for (i = shadow_count; i > at; i--) begin
						shadow_set[i] = shadow_set[i - 1];
					end
					shadow_set[at] = v;
					shadow_count++;
					if (need > shadow_class) begin
						shadow_class = need;
					end
					a.ok = 1'b1;
				end
			end
			REQ_REMOVE: begin
				a.position = 9'(lo);
				if (hit) begin
					for (i = lo; i + 1 < shadow_count; i++) begin
						shadow_set[i] = shadow_set[i + 1];
					end
					shadow_count--;
					a.ok = 1'b1;
				end
			end
			REQ_FIND: begin
				a.position = 9'(lo);
				a.ok = hit;
			end
			default: begin
				a.position = 9'(w.index);
				if (w.index < shadow_count) begin
					a.ok = 1'b1;
					a.read_value = shadow_set[w.index];
				end
			end
		endcase
		a.count = 9'(shadow_count);
		a.width_class = shadow_class;
		if (shadow_count > peak) begin
			peak = shadow_count;
		end
		return a;
	endfunction

	function automatic logic signed [63:0] draw_value();
		int                 s;
		logic signed [63:0] v;
		case ($urandom_range(9))
			0, 1, 2: begin
				// narrow band so values collide
				s = $urandom_range(400);
				v = 64'(s - 200);
			end
			3, 4: begin
				s = $urandom();
				v = 64'(s);
			end
			5, 6, 7: begin
				v = {$urandom(), $urandom()};
			end
			8: begin
				case ($urandom_range(7))
					0: v = INT64_MIN;
					1: v = INT64_MAX;
					2: v = CLASS32_LO;
					3: v = CLASS32_HI;
					4: v = CLASS16_LO;
					5: v = CLASS16_HI;
					6: v = 0;
					default: v = -1;
				endcase
			end
			default: begin
				if (shadow_count > 0) begin
					v = shadow_set[$urandom_range(shadow_count - 1)];
					v = $urandom_range(1) ? v + 1 : v - 1;
				end else begin
					v = 0;
				end
			end
		endcase
		return v;
	endfunction

	// add-heavy while filling, remove-heavy while draining
	function automatic req_t draw_request();
		req_t w;
		int   roll;
		w.index = 8'($urandom_range(255));
		w.value = draw_value();
		roll = $urandom_range(99);
		if (roll < (filling ? 70 : 5)) begin
			w.req_type = REQ_ADD;
		end else if (roll < 75) begin
			w.req_type = REQ_REMOVE;
			if (shadow_count > 0 && $urandom_range(99) < (filling ? 50 : 85)) begin
				w.value = shadow_set[$urandom_range(shadow_count - 1)];
			end
		end else if (roll < 88) begin
			w.req_type = REQ_FIND;
			if (shadow_count > 0 && $urandom_range(1) == 1) begin
				w.value = shadow_set[$urandom_range(shadow_count - 1)];
			end
		end else begin
			w.req_type = REQ_READ;
			if (shadow_count > 0 && $urandom_range(1) == 1) begin
				w.index = 8'($urandom_range(shadow_count - 1));
			end
		end
		return w;
	endfunction

	task automatic add_row(input req_type_t op, input logic signed [63:0] v,
		input logic [7:0] ix, input bit typed, input bit ok, input int pos,
		input int cnt, input logic [1:0] wc);
		script_row_t r;
		r.w.req_type = op;
		r.w.value = v;
		r.w.index = ix;
		r.typed = typed;
		r.want = '0;
		r.want.ok = ok;
		r.want.position = 9'(pos);
		r.want.count = 9'(cnt);
		r.want.width_class = wc;
		script.push_back(r);
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input req_t w, input bit typed, input res_t want);
		res_t guess;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		guess = set_answer(w);
		answers_due.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		@(negedge clk);
		while (answers_due.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp,
		input logic [63:0] got);
		if (exp !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
			fails++;
		end
	endtask

	// receiver side: random stall plus one long hold
	initial begin
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	res_t due;
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (answers_due.size() == 0) begin
				$error("result word with nothing expected: 0x%0h", res);
				fails++;
			end else begin
				due = answers_due.pop_front();
				checked++;
				check_field("ok", 64'(due.ok), 64'(res.ok));
				check_field("position", 64'(due.position), 64'(res.position));
				check_field("read_value", due.read_value, res.read_value);
				check_field("count", 64'(due.count), 64'(res.count));
				check_field("width_class", 64'(due.width_class), 64'(res.width_class));
				check_field("full_res", 64'(due.full_res), 64'(res.full_res));
			end
		end
	end

	initial begin
		#48_000_000;
		$display("timeout with %0d results outstanding", answers_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		req_t w;
		res_t none;
		int   ph, k;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		none = '0;
		for (k = 0; k < SET_CAP; k++) begin
			shadow_set[k] = '0;
		end
		for (k = 0; k < 4; k++) begin
			op_tally[k] = 0;
		end

		// empty table, extremes, duplicates, class widening, out-of-range reads
		add_row(REQ_READ,   0,          8'd0,   1, 0, 0, 0, WC_16);
		add_row(REQ_FIND,   INT64_MAX,  8'd0,   1, 0, 0, 0, WC_16);
		add_row(REQ_REMOVE, INT64_MIN,  8'd0,   1, 0, 0, 0, WC_16);
		add_row(REQ_ADD,    0,          8'd0,   1, 1, 0, 1, WC_16);
		add_row(REQ_ADD,    CLASS16_HI, 8'd0,   1, 1, 1, 2, WC_16);
		add_row(REQ_ADD,    CLASS16_LO, 8'd0,   1, 1, 0, 3, WC_16);
		add_row(REQ_ADD,    0,          8'd0,   1, 0, 1, 3, WC_16);
		add_row(REQ_FIND,   32768,      8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_ADD,    32768,      8'd0,   1, 1, 3, 4, WC_32);
		add_row(REQ_ADD,    -32769,     8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_ADD,    CLASS32_LO, 8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_ADD,    CLASS32_HI, 8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_ADD,    INT64_MIN,  8'd0,   1, 1, 0, 8, WC_64);
		add_row(REQ_ADD,    INT64_MAX,  8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_ADD,    -1,         8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_FIND,   CLASS32_LO, 8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_REMOVE, 0,          8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_REMOVE, 0,          8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_READ,   0,          8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_READ,   0,          8'd255, 0, 0, 0, 0, WC_16);
		add_row(REQ_READ,   0,          8'd8,   0, 0, 0, 0, WC_16);
		add_row(REQ_REMOVE, INT64_MAX,  8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_REMOVE, INT64_MIN,  8'd0,   0, 0, 0, 0, WC_16);
		add_row(REQ_ADD,    64'sh5555_aaaa_5555_aaaa, 8'haa, 0, 0, 0, 0, WC_16);
		add_row(REQ_READ,   64'shaaaa_5555_aaaa_5555, 8'h55, 0, 0, 0, 0, WC_16);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (k = 0; k < script.size(); k++) begin
			send_word(script[k].w, script[k].typed, script[k].want);
		end
		settle();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 87;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 87;
				end
				default: begin
					send_idle_pct = 14;
					stall_pct = 14;
				end
			endcase
			for (k = 0; k < 300; k++) begin
				// long output hold while words keep coming
				if (ph == 0 && k == 40) begin
					hold_left = 600;
				end
				w = draw_request();
				send_word(w, 1'b0, none);
				if (filling && refused >= refused_mark + 6) begin
					filling = 1'b0;
				end else if (!filling && shadow_count <= 4) begin
					filling = 1'b1;
					refused_mark = refused;
				end
			end
			settle();
		end

		repeat (300) @(negedge clk);
		$display("requests: %0d add, %0d remove, %0d find, %0d read; peak fill %0d of %0d",
			op_tally[REQ_ADD], op_tally[REQ_REMOVE], op_tally[REQ_FIND],
			op_tally[REQ_READ], peak, SET_CAP);
		$display("%0d adds refused on a full table, %0d results checked, %0d mismatches",
			refused, checked, fails);
		if (fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
